### rtl/uart_baud_divisor_search_core_assert.svh
// assertion macros for the baud divisor search core
`ifndef UART_BAUD_DIVISOR_SEARCH_CORE_ASSERT_SVH
`define UART_BAUD_DIVISOR_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UBDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UBDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ubds_pkg.sv
// shared types and constants of the baud divisor search core
`default_nettype none
package ubds_pkg;

  localparam int BAUD_W = 24;
  localparam int CLK_W = 32;
  localparam int DIV_W = 13;
  localparam int CODE_W = 5;
  localparam int OSR_MIN = 4;
  localparam int OSR_MAX = 32;
  localparam int NUM_OSR = OSR_MAX - OSR_MIN + 1;
  localparam logic [CODE_W-1:0] BOTH_EDGE_LIMIT = 5'd6;
  localparam logic [DIV_W-1:0] DIV_MASK = 13'h1fff;
  localparam logic [CLK_W-1:0] CLK_RESET = 32'd80000000;

  // running best candidate handed from cell to cell
  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    logic [CLK_W-1:0]  err;
    logic [CODE_W-1:0] code;
    logic [DIV_W-1:0]  div;
  } cand_t;

  localparam int CAND_W = $bits(cand_t);

endpackage
`default_nettype wire

### rtl/ubds_div.sv
// pipelined restoring divider, one quotient bit per stage, payload alongside
`default_nettype none
module ubds_div #(
  parameter int W = ubds_pkg::CLK_W,
  parameter int PW = ubds_pkg::CAND_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [W-1:0]  divisor,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output logic [W-1:0]       quotient,
  output logic [PW-1:0]      out_pay
);

  logic          vld [0:W];
  logic [W-1:0]  rem [0:W];
  logic [W-1:0]  quo [0:W];
  logic [W-1:0]  dvd [0:W];
  logic [W-1:0]  dvs [0:W];
  logic [PW-1:0] pay [0:W];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign quo[0] = '0;
  assign dvd[0] = dividend;
  assign dvs[0] = divisor;
  assign pay[0] = in_pay;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0]   shifted;
    logic         ge;
    logic [W:0]   diff;
    logic [W-1:0] rem_next;

    always_comb begin
      shifted = {rem[i], dvd[i][W-1]};
      diff = shifted - {1'b0, dvs[i]};
      ge = (shifted >= {1'b0, dvs[i]});
      rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1] <= rem_next;
        quo[i+1] <= {quo[i][W-2:0], ge};
        dvd[i+1] <= {dvd[i][W-2:0], 1'b0};
        dvs[i+1] <= dvs[i];
        pay[i+1] <= pay[i];
      end
    end
  end

  assign out_valid = vld[W];
  assign quotient = quo[W];
  assign out_pay = pay[W];

endmodule
`default_nettype wire

### rtl/ubds_osr_cell.sv
// one oversampling ratio: divisor, error at d and d+1, best-so-far update
`default_nettype none
module ubds_osr_cell #(
  parameter int OSR = ubds_pkg::OSR_MIN
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [ubds_pkg::CLK_W-1:0]    clk_hz,
  input  wire logic                          in_valid,
  input  wire ubds_pkg::cand_t               in_cand,
  output logic                               out_valid,
  output ubds_pkg::cand_t                    out_cand
);

  localparam int W = ubds_pkg::CLK_W;
  localparam int DW = ubds_pkg::DIV_W;
  localparam logic [W-1:0] OSR_V = W'(OSR);
  localparam logic [ubds_pkg::CODE_W-1:0] CODE_V = ubds_pkg::CODE_W'(OSR - 1);

  // stage 0: baud * osr
  logic            s0_valid;
  ubds_pkg::cand_t s0_cand;
  logic [W-1:0]    s0_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
    if (en) begin
      s0_cand <= in_cand;
      s0_prod <= {{(W-ubds_pkg::BAUD_W){1'b0}}, in_cand.baud} * OSR_V;
    end
  end

  logic                        d1_valid;
  logic [W-1:0]                d1_q;
  logic [ubds_pkg::CAND_W-1:0] d1_pay;

  ubds_div #(.W(W), .PW(ubds_pkg::CAND_W)) u_div_q (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s0_valid), .dividend(clk_hz), .divisor(s0_prod), .in_pay(s0_cand),
    .out_valid(d1_valid), .quotient(d1_q), .out_pay(d1_pay)
  );

  // stage 1: masked divisor, zero forced to one, osr*d and osr*(d+1)
  logic [DW-1:0] dsel;
  logic [W-1:0]  dsel_w;
  logic          s1_valid;
  ubds_pkg::cand_t s1_cand;
  logic [DW-1:0] s1_d;
  logic [W-1:0]  s1_m0;
  logic [W-1:0]  s1_m1;

  always_comb begin
    dsel = (d1_q[DW-1:0] == '0) ? DW'(1) : d1_q[DW-1:0];
    dsel_w = {{(W-DW){1'b0}}, dsel};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= d1_valid;
    end
    if (en) begin
      s1_cand <= d1_pay;
      s1_d <= dsel;
      s1_m0 <= dsel_w * OSR_V;
      s1_m1 <= (dsel_w + W'(1)) * OSR_V;
    end
  end

  logic                        d2_valid;
  logic [W-1:0]                d2_q;
  logic [ubds_pkg::CAND_W-1:0] d2_pay;
  logic                        d3_valid;
  logic [W-1:0]                d3_q;
  logic [DW-1:0]               d3_pay;

  ubds_div #(.W(W), .PW(ubds_pkg::CAND_W)) u_div_lo (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s1_valid), .dividend(clk_hz), .divisor(s1_m0), .in_pay(s1_cand),
    .out_valid(d2_valid), .quotient(d2_q), .out_pay(d2_pay)
  );

  ubds_div #(.W(W), .PW(DW)) u_div_hi (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s1_valid), .dividend(clk_hz), .divisor(s1_m1), .in_pay(s1_d),
    .out_valid(d3_valid), .quotient(d3_q), .out_pay(d3_pay)
  );

  // stage 2: both errors, wrapping as unsigned
  ubds_pkg::cand_t s2_cand;
  logic            s2_valid;
  logic [W-1:0]    s2_err;
  logic [W-1:0]    s2_alt;
  logic [DW-1:0]   s2_d;
  ubds_pkg::cand_t d2_cand;

  assign d2_cand = d2_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= d2_valid & d3_valid;
    end
    if (en) begin
      s2_cand <= d2_cand;
      s2_d <= d3_pay;
      s2_err <= d2_q - {{(W-ubds_pkg::BAUD_W){1'b0}}, d2_cand.baud};
      s2_alt <= {{(W-ubds_pkg::BAUD_W){1'b0}}, d2_cand.baud} - d3_q;
    end
  end

  // stage 3: pick d or d+1, then later ratio wins a tie
  logic            up;
  logic [W-1:0]    err;
  logic [DW-1:0]   dn;
  ubds_pkg::cand_t next_cand;

  always_comb begin
    up = (s2_err > s2_alt);
    err = up ? s2_alt : s2_err;
    dn = (up && (s2_d < ubds_pkg::DIV_MASK)) ? s2_d + DW'(1) : s2_d;
    next_cand = s2_cand;
    if (err <= s2_cand.err) begin
      next_cand.err = err;
      next_cand.code = CODE_V;
      next_cand.div = dn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
    if (en) begin
      out_cand <= next_cand;
    end
  end

endmodule
`default_nettype wire

### rtl/uart_baud_divisor_search_core.sv
// baud divisor search: a row of 29 oversampling cells and an output register
// an accepted input word passes through all 29 cells and then the output register;
//   each cell holds three 32-stage dividers
// throughput: one word per cycle, the whole pipeline stalls only when the
//   output register is full, not taken, and a result reaches the last cell
// reset: clears all valid bits, module clock register returns to 80000000
`default_nettype none
`include "uart_baud_divisor_search_core_assert.svh"
module uart_baud_divisor_search_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // baud_rate[23:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // oversample_code[4:0], both_edge[5], divisor[18:6]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data   // module_clock_hz
);

  localparam int N = ubds_pkg::NUM_OSR;

  logic [ubds_pkg::CLK_W-1:0] clk_hz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz <= ubds_pkg::CLK_RESET;
    end else if (cfg_valid) begin
      clk_hz <= cfg_data;
    end
  end

  logic            en;
  logic            chain_valid [0:N];
  ubds_pkg::cand_t chain_cand [0:N];
  ubds_pkg::cand_t first_cand;

  always_comb begin
    first_cand.baud = s_tdata[ubds_pkg::BAUD_W-1:0];
    first_cand.err = {{(ubds_pkg::CLK_W-ubds_pkg::BAUD_W){1'b0}}, s_tdata[ubds_pkg::BAUD_W-1:0]};
    first_cand.code = '0;
    first_cand.div = '0;
  end

  assign chain_valid[0] = s_tvalid & s_tready;
  assign chain_cand[0] = first_cand;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ubds_osr_cell #(.OSR(ubds_pkg::OSR_MIN + i)) u_cell (
      .clk(clk), .rst(rst), .en(en), .clk_hz(clk_hz),
      .in_valid(chain_valid[i]), .in_cand(chain_cand[i]),
      .out_valid(chain_valid[i+1]), .out_cand(chain_cand[i+1])
    );
  end

  logic last_valid;
  ubds_pkg::cand_t last_cand;

  assign last_valid = chain_valid[N];
  assign last_cand = chain_cand[N];
  assign en = ~m_tvalid | m_tready | ~last_valid;
  assign s_tready = en;

  logic [ubds_pkg::CODE_W-1:0] out_code;
  logic                        out_both;
  logic [ubds_pkg::DIV_W-1:0]  out_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en && last_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (en && last_valid) begin
      // zero baud gives an all-zero word
      if (last_cand.baud == '0) begin
        out_code <= '0;
        out_both <= 1'b0;
        out_div <= '0;
      end else begin
        out_code <= last_cand.code;
        out_both <= (last_cand.code <= ubds_pkg::BOTH_EDGE_LIMIT);
        out_div <= last_cand.div;
      end
    end
  end

  assign m_tdata = {5'b0, out_div, out_both, out_code};

  `UBDS_ASSERT_NEXT(a_stall_keeps_word, !en, m_tvalid, "stalled output word was dropped")
  `UBDS_ASSERT_NEXT(a_result_lands, en && last_valid, m_tvalid, "result from last cell lost")
  `UBDS_ASSERT_NOW(a_full_blocks_input, m_tvalid && !m_tready && last_valid, !s_tready,
                   "input taken while pipeline is blocked")

endmodule
`default_nettype wire
